// ----- design/arf_pkg.sv -----
package arf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HeapW    = 24;
  localparam int unsigned RateW    = 8;
  localparam int unsigned WinW     = 16;
  localparam int unsigned EntryW   = 2 * KeyW + TimeW;

  localparam logic [WinW-1:0]  WindowMsRst      = 16'd1000;
  localparam logic [RateW-1:0] NormalRateRst    = 8'd4;
  localparam logic [RateW-1:0] BootRateRst      = 8'd2;
  localparam logic [RateW-1:0] EmergencyRateRst = 8'd1;
  localparam logic [TimeW-1:0] BootEndMsRst     = 32'd60000;
  localparam logic [HeapW-1:0] HeapThresholdRst = 24'd15000;
  localparam logic [TimeW-1:0] RevalidateMsRst  = 32'd300000;
  localparam logic [RateW-1:0] CountMax         = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_MS      = 3'd0,
    CFG_NORMAL_RATE    = 3'd1,
    CFG_BOOT_RATE      = 3'd2,
    CFG_EMERGENCY_RATE = 3'd3,
    CFG_BOOT_END_MS    = 3'd4,
    CFG_HEAP_THRESHOLD = 3'd5,
    CFG_REVALIDATE_MS  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_SEARCH,
    ST_PASS,
    ST_DROP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic cap_item;
    logic rate_step;
    logic search_start;
    logic search_step;
    logic wr_hit;
    logic wr_miss;
    logic out_load;
    logic out_value;
  } cmd_t;

  typedef struct packed {
    logic is_announce;
    logic path_known;
    logic over_rate;
    logic hit;
    logic repeat_seen;
    logic miss;
    logic out_free;
  } status_t;

endpackage

// ----- design/arf_channels.sv -----
interface arf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          is_announce;
  logic [arf_pkg::TimeW-1:0]     now_ms;
  logic [arf_pkg::HeapW-1:0]     free_heap;
  logic                          path_known;
  logic [arf_pkg::KeyW-1:0]      dest_hash_hi;
  logic [arf_pkg::KeyW-1:0]      dest_hash_lo;

  modport source (output valid, is_announce, now_ms, free_heap, path_known,
                  dest_hash_hi, dest_hash_lo, input ready);
  modport sink   (input valid, is_announce, now_ms, free_heap, path_known,
                  dest_hash_hi, dest_hash_lo, output ready);
endinterface

interface arf_out_if;
  logic valid;
  logic ready;
  logic accept;

  modport source (output valid, accept, input ready);
  modport sink   (input valid, accept, output ready);
endinterface

interface arf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [arf_pkg::CfgIdxW-1:0]    wr_index;
  logic [arf_pkg::CfgDataW-1:0]   wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ----- design/announce_rate_filter.sv -----
// Admission filter for received packets. Each word on in_i describes one
// packet; out_o returns exactly one word per input with accept = 1 to pass
// the packet on or 0 to drop it, in input order. cfg_i writes the seven
// configuration registers by index; it is always ready and unknown indexes
// are ignored. Write configuration only while no packet is in flight.
// One packet is processed at a time. A packet that is not an announce, or
// an announce without a known path or dropped by the rate check, goes
// from the rate check straight to the PASS or DROP state, which loads its
// result word into the output register. An announce with a known path
// searches the hash table one entry per cycle through the table memory's
// single read port: a miss reads every filled entry and a hit ends the
// search at the matching entry. The controller returns to idle as the
// result is registered, so the next input word can be taken even while
// that result still waits on out_o. When the receiver stalls, the
// result word is held and a further result waits in the controller.
// Reset restores the default configuration, restarts the rate window at
// time zero and empties the table at once; no clearing pass is needed.
module announce_rate_filter #(
  parameter int unsigned TABLE_CAP = 40
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  arf_in_if.sink   in_i,
  arf_out_if.source out_o,
  arf_cfg_if.sink  cfg_i
);

  arf_pkg::cmd_t    cmd;
  arf_pkg::status_t status;

  assign in_i.ready  = cmd.in_ready;
  assign cfg_i.ready = 1'b1;

  arf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  arf_datapath #(
    .TableCap (TABLE_CAP)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .is_announce_i  (in_i.is_announce),
    .now_ms_i       (in_i.now_ms),
    .free_heap_i    (in_i.free_heap),
    .path_known_i   (in_i.path_known),
    .dest_hash_hi_i (in_i.dest_hash_hi),
    .dest_hash_lo_i (in_i.dest_hash_lo),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.wr_index),
    .cfg_data_i     (cfg_i.wr_data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_accept_o   (out_o.accept)
  );

endmodule

// ----- design/arf_ram.sv -----
module arf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/arf_ctrl.sv -----
module arf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  arf_pkg::status_t status_i,
  output arf_pkg::cmd_t    cmd_o
);

  arf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      arf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = arf_pkg::ST_RATE;
      end
      arf_pkg::ST_RATE: begin
        if (!status_i.is_announce) state_d = arf_pkg::ST_PASS;
        else if (status_i.over_rate) state_d = arf_pkg::ST_DROP;
        else if (status_i.path_known) state_d = arf_pkg::ST_SEARCH;
        else state_d = arf_pkg::ST_PASS;
      end
      arf_pkg::ST_SEARCH: begin
        if (status_i.hit) begin
          state_d = status_i.repeat_seen ? arf_pkg::ST_DROP : arf_pkg::ST_PASS;
        end else if (status_i.miss) begin
          state_d = arf_pkg::ST_PASS;
        end
      end
      arf_pkg::ST_PASS, arf_pkg::ST_DROP: begin
        if (status_i.out_free) state_d = arf_pkg::ST_IDLE;
      end
      default: state_d = arf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      arf_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.cap_item = in_valid_i;
      end
      arf_pkg::ST_RATE: begin
        cmd_o.rate_step    = status_i.is_announce;
        cmd_o.search_start = 1'b1;
      end
      arf_pkg::ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        cmd_o.wr_hit      = status_i.hit && !status_i.repeat_seen;
        cmd_o.wr_miss     = !status_i.hit && status_i.miss;
      end
      arf_pkg::ST_PASS: begin
        cmd_o.out_load  = status_i.out_free;
        cmd_o.out_value = 1'b1;
      end
      arf_pkg::ST_DROP: begin
        cmd_o.out_load  = status_i.out_free;
        cmd_o.out_value = 1'b0;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/arf_datapath.sv -----
module arf_datapath #(
  parameter int unsigned TableCap = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  arf_pkg::cmd_t                   cmd_i,
  output arf_pkg::status_t                status_o,
  input  logic                            is_announce_i,
  input  logic [arf_pkg::TimeW-1:0]       now_ms_i,
  input  logic [arf_pkg::HeapW-1:0]       free_heap_i,
  input  logic                            path_known_i,
  input  logic [arf_pkg::KeyW-1:0]        dest_hash_hi_i,
  input  logic [arf_pkg::KeyW-1:0]        dest_hash_lo_i,
  input  logic                            cfg_we_i,
  input  logic [arf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [arf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_accept_o
);

  localparam int unsigned Depth = TableCap + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(TableCap + 2);

  // Configuration registers.
  logic [arf_pkg::WinW-1:0]  window_ms_q;
  logic [arf_pkg::RateW-1:0] normal_rate_q, boot_rate_q, emergency_rate_q;
  logic [arf_pkg::TimeW-1:0] boot_end_ms_q, revalidate_ms_q;
  logic [arf_pkg::HeapW-1:0] heap_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms_q      <= arf_pkg::WindowMsRst;
      normal_rate_q    <= arf_pkg::NormalRateRst;
      boot_rate_q      <= arf_pkg::BootRateRst;
      emergency_rate_q <= arf_pkg::EmergencyRateRst;
      boot_end_ms_q    <= arf_pkg::BootEndMsRst;
      heap_threshold_q <= arf_pkg::HeapThresholdRst;
      revalidate_ms_q  <= arf_pkg::RevalidateMsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        arf_pkg::CFG_WINDOW_MS:      window_ms_q      <= cfg_data_i[arf_pkg::WinW-1:0];
        arf_pkg::CFG_NORMAL_RATE:    normal_rate_q    <= cfg_data_i[arf_pkg::RateW-1:0];
        arf_pkg::CFG_BOOT_RATE:      boot_rate_q      <= cfg_data_i[arf_pkg::RateW-1:0];
        arf_pkg::CFG_EMERGENCY_RATE: emergency_rate_q <= cfg_data_i[arf_pkg::RateW-1:0];
        arf_pkg::CFG_BOOT_END_MS:    boot_end_ms_q    <= cfg_data_i[arf_pkg::TimeW-1:0];
        arf_pkg::CFG_HEAP_THRESHOLD: heap_threshold_q <= cfg_data_i[arf_pkg::HeapW-1:0];
        arf_pkg::CFG_REVALIDATE_MS:  revalidate_ms_q  <= cfg_data_i[arf_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic                      is_announce_q, path_known_q;
  logic [arf_pkg::TimeW-1:0] now_q;
  logic [arf_pkg::HeapW-1:0] heap_q;
  logic [arf_pkg::KeyW-1:0]  hash_hi_q, hash_lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      is_announce_q <= is_announce_i;
      now_q         <= now_ms_i;
      heap_q        <= free_heap_i;
      path_known_q  <= path_known_i;
      hash_hi_q     <= dest_hash_hi_i;
      hash_lo_q     <= dest_hash_lo_i;
    end
  end

  // Window and rate check.
  logic [arf_pkg::TimeW-1:0] win_start_q, elapsed;
  logic [arf_pkg::RateW-1:0] count_q, count_base, count_inc, rate_sel;
  logic                      restart;

  always_comb begin
    elapsed    = now_q - win_start_q;
    restart    = elapsed >= {{(arf_pkg::TimeW - arf_pkg::WinW){1'b0}}, window_ms_q};
    count_base = restart ? '0 : count_q;
    count_inc  = (count_base == arf_pkg::CountMax) ? count_base : count_base + 1'b1;
    if (heap_q < heap_threshold_q) rate_sel = emergency_rate_q;
    else if (now_q < boot_end_ms_q) rate_sel = boot_rate_q;
    else rate_sel = normal_rate_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      count_q     <= '0;
    end else if (cmd_i.rate_step) begin
      if (restart) win_start_q <= now_q;
      count_q <= count_inc;
    end
  end

  // Table search: one read issued per cycle, compared in the cycle after.
  logic [FillW-1:0]          fill_q, idx_q;
  logic [IdxW-1:0]           cmp_idx_q, waddr;
  logic                      cmp_vld_q, rd_issue;
  logic [arf_pkg::EntryW-1:0] rdata, wdata;
  logic [arf_pkg::KeyW-1:0]  rd_hi, rd_lo;
  logic [arf_pkg::TimeW-1:0] rd_time, age;

  assign rd_issue = idx_q < fill_q;
  assign rd_hi    = rdata[arf_pkg::EntryW-1 -: arf_pkg::KeyW];
  assign rd_lo    = rdata[arf_pkg::TimeW +: arf_pkg::KeyW];
  assign rd_time  = rdata[arf_pkg::TimeW-1:0];
  assign age      = now_q - rd_time;
  assign waddr    = cmd_i.wr_hit ? cmp_idx_q : fill_q[IdxW-1:0];
  assign wdata    = {hash_hi_q, hash_lo_q, now_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      fill_q    <= '0;
    end else begin
      if (cmd_i.search_start) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search_step) begin
        cmp_vld_q <= rd_issue;
        cmp_idx_q <= idx_q[IdxW-1:0];
        if (rd_issue) idx_q <= idx_q + 1'b1;
      end
      // The whole table is dropped once it would hold more than the cap.
      if (cmd_i.wr_miss) begin
        fill_q <= (fill_q == FillW'(TableCap)) ? '0 : fill_q + 1'b1;
      end
    end
  end

  arf_ram #(
    .Width (arf_pkg::EntryW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_hit || cmd_i.wr_miss),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.search_step && rd_issue),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  // Output register.
  logic out_valid_q, out_accept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_accept_q <= cmd_i.out_value;
  end

  assign out_valid_o  = out_valid_q;
  assign out_accept_o = out_accept_q;

  always_comb begin
    status_o.is_announce = is_announce_q;
    status_o.path_known  = path_known_q;
    status_o.over_rate   = count_inc > rate_sel;
    status_o.hit         = cmp_vld_q && (rd_hi == hash_hi_q) && (rd_lo == hash_lo_q);
    status_o.repeat_seen = age < revalidate_ms_q;
    status_o.miss        = !cmp_vld_q && (idx_q == fill_q);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule
